// ===== design/msgpack_header_encoder_top_assert.svh =====
// Assertion macros shared by the MessagePack header encoder modules.
`ifndef MSGPACK_HEADER_ENCODER_TOP_ASSERT_SVH
`define MSGPACK_HEADER_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define MHE_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mhe: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define MHE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mhe: next-cycle check failed");
`else
`define MHE_ASSERT_SAME(name, ante, cons)
`define MHE_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== design/mhe_pkg.sv =====
// Types and constants of the MessagePack header encoder.
package mhe_pkg;

   localparam int KindWidth  = 3;
   localparam int ValueWidth = 64;
   localparam int ByteWidth  = 8;
   localparam int CountWidth = 4;

   typedef enum logic [KindWidth-1:0] {
      KIND_UINT = 3'd0,
      KIND_STR  = 3'd1,
      KIND_ARR  = 3'd2,
      KIND_MAP  = 3'd3,
      KIND_BIN  = 3'd4
   } kind_type;

   localparam logic [7:0] TAG_FIXSTR = 8'ha0;
   localparam logic [7:0] TAG_FIXARR = 8'h90;
   localparam logic [7:0] TAG_FIXMAP = 8'h80;
   localparam logic [7:0] TAG_UINT8  = 8'hcc;
   localparam logic [7:0] TAG_UINT16 = 8'hcd;
   localparam logic [7:0] TAG_UINT32 = 8'hce;
   localparam logic [7:0] TAG_UINT64 = 8'hcf;
   localparam logic [7:0] TAG_STR8   = 8'hd9;
   localparam logic [7:0] TAG_STR16  = 8'hda;
   localparam logic [7:0] TAG_STR32  = 8'hdb;
   localparam logic [7:0] TAG_ARR16  = 8'hdc;
   localparam logic [7:0] TAG_ARR32  = 8'hdd;
   localparam logic [7:0] TAG_MAP16  = 8'hde;
   localparam logic [7:0] TAG_MAP32  = 8'hdf;
   localparam logic [7:0] TAG_BIN8   = 8'hc4;
   localparam logic [7:0] TAG_BIN16  = 8'hc5;
   localparam logic [7:0] TAG_BIN32  = 8'hc6;

   // One decoded request: type byte, value bytes left-aligned, their count, error flag.
   typedef struct packed {
      logic [ByteWidth-1:0]  tag;
      logic [ValueWidth-1:0] data;
      logic [CountWidth-1:0] nbytes;
      logic                  error;
   } ser_item_type;

endpackage

// ===== design/mhe_req_if.sv =====
// Request channel of the MessagePack header encoder.
interface mhe_req_if import mhe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [KindWidth-1:0]  kind;
   logic [ValueWidth-1:0] value;

   modport source(output valid, kind, value, input ready);
   modport sink(input valid, kind, value, output ready);
endinterface

// ===== design/mhe_rsp_if.sv =====
// Response channel of the MessagePack header encoder.
interface mhe_rsp_if import mhe_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] out_byte;
   logic                 last;
   logic                 error;

   modport source(output valid, out_byte, last, error, input ready);
   modport sink(input valid, out_byte, last, error, output ready);
endinterface

// ===== design/mhe_ser.sv =====
// Byte serializer with output register for the MessagePack header encoder.
`include "msgpack_header_encoder_top_assert.svh"
module mhe_ser import mhe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  ser_item_type  in_item,
   mhe_rsp_if.source     rsp_ch
);

   logic                  busy_ff, busy_in;
   logic                  first_ff, first_in;
   logic [ByteWidth-1:0]  tag_ff, tag_in;
   logic [ValueWidth-1:0] data_ff, data_in;
   logic [CountWidth-1:0] left_ff, left_in;
   logic                  err_ff, err_in;

   logic                  out_valid_ff, out_valid_in;
   logic [ByteWidth-1:0]  byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic                  error_ff, error_in;

   logic                  out_load;
   logic                  emit;
   logic                  cur_last;
   logic [ByteWidth-1:0]  cur_byte;

   assign out_load = !out_valid_ff || rsp_ch.ready;
   assign emit     = busy_ff && out_load;
   assign cur_byte = first_ff ? tag_ff : data_ff[ValueWidth-1 -: ByteWidth];
   assign cur_last = first_ff ? (left_ff == '0) : (left_ff == CountWidth'(1));
   assign in_ready = !busy_ff || (emit && cur_last);

   always_comb begin
      busy_in  = busy_ff;
      first_in = first_ff;
      tag_in   = tag_ff;
      data_in  = data_ff;
      left_in  = left_ff;
      err_in   = err_ff;
      if (emit) begin
         if (cur_last) begin
            busy_in = 1'b0;
         end else if (first_ff) begin
            first_in = 1'b0;
         end else begin
            left_in = left_ff - CountWidth'(1);
            data_in = {data_ff[ValueWidth-ByteWidth-1:0], {ByteWidth{1'b0}}};
         end
      end
      // take the next request as the current one finishes
      if (in_valid && in_ready) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         tag_in   = in_item.tag;
         data_in  = in_item.data;
         left_in  = in_item.nbytes;
         err_in   = in_item.error;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      error_in     = error_ff;
      if (out_load) begin
         out_valid_in = emit;
         byte_in      = cur_byte;
         last_in      = cur_last;
         error_in     = err_ff && first_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         first_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
      tag_ff   <= tag_in;
      data_ff  <= data_in;
      left_ff  <= left_in;
      err_ff   <= err_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      error_ff <= error_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_byte = byte_ff;
   assign rsp_ch.last     = last_ff;
   assign rsp_ch.error    = error_ff;

   `MHE_ASSERT_SAME(a_err_is_last, out_valid_ff && error_ff, last_ff)
   `MHE_ASSERT_SAME(a_err_byte_zero, out_valid_ff && error_ff, byte_ff == '0)
   `MHE_ASSERT_SAME(a_left_range, busy_ff, left_ff <= CountWidth'(8))
   `MHE_ASSERT_SAME(a_body_pending, busy_ff && !first_ff, left_ff != '0)

endmodule

// ===== design/msgpack_header_encoder_top.sv =====
// Top level of the MessagePack header encoder.
//
// Each request names an element kind (uint, string, array, map or binary
// header) and a 64-bit value or length; the block answers with the shortest
// MessagePack encoding, one response per byte: the type byte first, then the
// big-endian value or length, with last set on the final byte. A header
// length above 32 bits, or an unknown kind, gives a single response with
// out_byte zero, last and error set. An item occupies the output for one
// response per byte of its encoding: a single byte for a fix form, up to
// nine for a 64-bit uint. Requests of short encodings follow each other
// without gaps. A request passes through the input register with range
// compares, the register after decode and byte alignment, the serializer
// and the output register. Backpressure on the response channel stalls
// all stages in place without losing or repeating any request.
module msgpack_header_encoder_top import mhe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mhe_req_if.sink   req_ch,
   mhe_rsp_if.source rsp_ch
);

   // Stage 1: register the request and the magnitude flags of the value.
   logic                  s1_valid_ff, s1_valid_in;
   logic [KindWidth-1:0]  s1_kind_ff, s1_kind_in;
   logic [ValueWidth-1:0] s1_value_ff, s1_value_in;
   logic                  s1_over32_ff, s1_over32_in;
   logic                  s1_over16_ff, s1_over16_in;
   logic                  s1_over8_ff, s1_over8_in;
   logic                  s1_ready;

   // Stage 2: decoded item waiting for the serializer.
   logic                  s2_valid_ff, s2_valid_in;
   ser_item_type          s2_item_ff, s2_item_in;
   logic                  s2_ready;

   ser_item_type          dec_item;
   logic                  ser_ready;

   assign s2_ready     = !s2_valid_ff || ser_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_ch.ready = s1_ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_kind_in   = s1_kind_ff;
      s1_value_in  = s1_value_ff;
      s1_over32_in = s1_over32_ff;
      s1_over16_in = s1_over16_ff;
      s1_over8_in  = s1_over8_ff;
      if (s1_ready) begin
         s1_valid_in  = req_ch.valid;
         s1_kind_in   = req_ch.kind;
         s1_value_in  = req_ch.value;
         s1_over32_in = |req_ch.value[63:32];
         s1_over16_in = |req_ch.value[63:16];
         s1_over8_in  = |req_ch.value[63:8];
      end
   end

   // Pick type byte and byte count; flag a header length over 32 bits or an unknown kind as an error.
   always_comb begin
      logic [7:0] lo;
      lo = s1_value_ff[7:0];
      dec_item.tag    = '0;
      dec_item.nbytes = '0;
      dec_item.error  = 1'b0;
      unique case (s1_kind_ff)
         KIND_UINT: begin
            if (!s1_over8_ff && !lo[7]) begin
               dec_item.tag = lo;
            end else if (!s1_over8_ff) begin
               dec_item.tag = TAG_UINT8;  dec_item.nbytes = CountWidth'(1);
            end else if (!s1_over16_ff) begin
               dec_item.tag = TAG_UINT16; dec_item.nbytes = CountWidth'(2);
            end else if (!s1_over32_ff) begin
               dec_item.tag = TAG_UINT32; dec_item.nbytes = CountWidth'(4);
            end else begin
               dec_item.tag = TAG_UINT64; dec_item.nbytes = CountWidth'(8);
            end
         end
         KIND_STR: begin
            if (s1_over32_ff) begin
               dec_item.error = 1'b1;
            end else if (!s1_over8_ff && lo[7:5] == 3'b000) begin
               dec_item.tag = TAG_FIXSTR | lo;
            end else if (!s1_over8_ff) begin
               dec_item.tag = TAG_STR8;  dec_item.nbytes = CountWidth'(1);
            end else if (!s1_over16_ff) begin
               dec_item.tag = TAG_STR16; dec_item.nbytes = CountWidth'(2);
            end else begin
               dec_item.tag = TAG_STR32; dec_item.nbytes = CountWidth'(4);
            end
         end
         KIND_ARR: begin
            if (s1_over32_ff) begin
               dec_item.error = 1'b1;
            end else if (!s1_over8_ff && lo[7:4] == 4'h0) begin
               dec_item.tag = TAG_FIXARR | lo;
            end else if (!s1_over16_ff) begin
               dec_item.tag = TAG_ARR16; dec_item.nbytes = CountWidth'(2);
            end else begin
               dec_item.tag = TAG_ARR32; dec_item.nbytes = CountWidth'(4);
            end
         end
         KIND_MAP: begin
            if (s1_over32_ff) begin
               dec_item.error = 1'b1;
            end else if (!s1_over8_ff && lo[7:4] == 4'h0) begin
               dec_item.tag = TAG_FIXMAP | lo;
            end else if (!s1_over16_ff) begin
               dec_item.tag = TAG_MAP16; dec_item.nbytes = CountWidth'(2);
            end else begin
               dec_item.tag = TAG_MAP32; dec_item.nbytes = CountWidth'(4);
            end
         end
         KIND_BIN: begin
            if (s1_over32_ff) begin
               dec_item.error = 1'b1;
            end else if (!s1_over8_ff) begin
               dec_item.tag = TAG_BIN8;  dec_item.nbytes = CountWidth'(1);
            end else if (!s1_over16_ff) begin
               dec_item.tag = TAG_BIN16; dec_item.nbytes = CountWidth'(2);
            end else begin
               dec_item.tag = TAG_BIN32; dec_item.nbytes = CountWidth'(4);
            end
         end
         default: begin
            // unknown kinds report an error
            dec_item.error = 1'b1;
         end
      endcase
      // Left-align the value bytes so the serializer always takes the top byte.
      unique case (dec_item.nbytes)
         CountWidth'(1): dec_item.data = s1_value_ff << 56;
         CountWidth'(2): dec_item.data = s1_value_ff << 48;
         CountWidth'(4): dec_item.data = s1_value_ff << 32;
         default:        dec_item.data = s1_value_ff;
      endcase
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_item_in  = s2_item_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         s2_item_in  = dec_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_kind_ff   <= s1_kind_in;
      s1_value_ff  <= s1_value_in;
      s1_over32_ff <= s1_over32_in;
      s1_over16_ff <= s1_over16_in;
      s1_over8_ff  <= s1_over8_in;
      s2_item_ff   <= s2_item_in;
   end

   // Stages 3 and 4: serialize one byte per cycle into the output register unless stalled.
   mhe_ser u_ser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid_ff),
      .in_ready (ser_ready),
      .in_item  (s2_item_ff),
      .rsp_ch   (rsp_ch)
   );

endmodule
